/* rtl/core/ajv_pkg.sv */
// Shared types, constants and fixed-point helpers for the arm Jacobian velocity core.
// Used by every module under rtl/core; depends on nothing else.
package ajv_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int QUAD_BITS  = ANGLE_BITS - 2;

    // One pipeline register at the input, eight in each sine lane, four in the
    // Jacobian builder, two in each row lane and one at the output.
    localparam int SIN_STAGES = 8;
    localparam int JAC_STAGES = 4;
    localparam int ROW_STAGES = 2;
    localparam int PIPE_DEPTH = 1 + SIN_STAGES + JAC_STAGES + ROW_STAGES + 1;
    localparam int RATE_DELAY = SIN_STAGES + JAC_STAGES;

    typedef logic signed [35:0] t_coef;
    typedef logic signed [31:0] t_rate;
    typedef logic signed [70:0] t_sum;
    typedef logic [ANGLE_BITS-1:0] t_angle;

    localparam t_coef TRIG_ONE = 36'sd1073741824;
    localparam t_coef C11      = -36'sd3864;
    localparam t_coef POLY_C [0:4] = '{
        36'sd172272, -36'sd5026995, 36'sd85569304, -36'sd693598668, 36'sd1686629713
    };

    localparam t_angle QUARTER_TURN = t_angle'(1) << QUAD_BITS;

    // Register indexes of the configuration port.
    localparam logic [7:0] CFG_UPPER_ARM      = 8'd0;
    localparam logic [7:0] CFG_FOREARM_OFFSET = 8'd1;
    localparam logic [7:0] CFG_SHOULDER       = 8'd2;
    localparam logic [7:0] CFG_FOREARM_LENGTH = 8'd3;

    // Sine lane assignment.
    localparam int L_S1  = 0;
    localparam int L_C1  = 1;
    localparam int L_S2  = 2;
    localparam int L_C2  = 3;
    localparam int L_S4  = 4;
    localparam int L_C4  = 5;
    localparam int L_S5  = 6;
    localparam int L_C5  = 7;
    localparam int L_S23 = 8;
    localparam int L_C23 = 9;
    localparam int SIN_LANES = 10;

    typedef struct packed {
        logic signed [15:0] joint1_angle;
        logic signed [15:0] joint2_angle;
        logic signed [15:0] joint3_angle;
        logic signed [15:0] joint4_angle;
        logic signed [15:0] joint5_angle;
        logic signed [15:0] joint6_angle;
        logic signed [31:0] joint1_rate;
        logic signed [31:0] joint2_rate;
        logic signed [31:0] joint3_rate;
        logic signed [31:0] joint4_rate;
        logic signed [31:0] joint5_rate;
        logic signed [31:0] joint6_rate;
    } t_in;

    typedef struct packed {
        logic signed [31:0] linear_vel_x;
        logic signed [31:0] linear_vel_y;
        logic signed [31:0] linear_vel_z;
        logic signed [31:0] angular_vel_x;
        logic signed [31:0] angular_vel_y;
        logic signed [31:0] angular_vel_z;
    } t_out;

    // Q30 product with floor rounding, kept in the format of the first operand.
    function automatic t_coef mq(input t_coef a, input t_coef b);
        logic signed [71:0] p;
        p = a * b;
        return p[65:30];
    endfunction

    function automatic t_rate sat32(input t_sum v);
        if (v > t_sum'(64'sh7FFFFFFF)) begin
            return 32'sh7FFFFFFF;
        end else if (v < -t_sum'(64'sh80000000)) begin
            return -32'sh7FFFFFFF - 32'sd1;
        end
        return v[31:0];
    endfunction

endpackage

/* rtl/core/ajv_sine.sv */
// One sine lane: quadrant folding and a pipelined odd polynomial, Q6.30 out.
// Depends on ajv_pkg.
module ajv_sine (
    input  logic            i_clk,
    input  logic            i_en,
    input  ajv_pkg::t_angle i_angle,
    output ajv_pkg::t_coef  o_sine
);
    import ajv_pkg::*;

    logic [1:0]         quad;
    logic [QUAD_BITS:0] r_lo;
    logic [QUAD_BITS:0] folded;
    t_coef              x_start;
    t_coef              prod;
    t_coef              clamped;

    t_coef r_t   [1:7];
    logic  r_neg [1:7];
    t_coef r_u   [2:6];
    t_coef r_acc [3:7];
    t_coef r_sine;

    always_comb begin
        quad    = i_angle[ANGLE_BITS-1 -: 2];
        r_lo    = {1'b0, i_angle[QUAD_BITS-1:0]};
        folded  = quad[0] ? ((QUAD_BITS+1)'(1) << QUAD_BITS) - r_lo : r_lo;
        x_start = t_coef'({folded, (32-ANGLE_BITS)'(0)});
        prod    = mq(r_acc[7], r_t[7]);
        if (prod < 0) begin
            clamped = '0;
        end else if (prod > TRIG_ONE) begin
            clamped = TRIG_ONE;
        end else begin
            clamped = prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[1]   <= x_start;
            r_neg[1] <= quad[1];
            for (int k = 2; k <= 7; k++) begin
                r_t[k]   <= r_t[k-1];
                r_neg[k] <= r_neg[k-1];
            end
            r_u[2] <= mq(r_t[1], r_t[1]);
            for (int k = 3; k <= 6; k++) begin
                r_u[k] <= r_u[k-1];
            end
            r_acc[3] <= POLY_C[0] + mq(C11, r_u[2]);
            for (int k = 4; k <= 7; k++) begin
                r_acc[k] <= POLY_C[k-3] + mq(r_acc[k-1], r_u[k-1]);
            end
            r_sine <= r_neg[7] ? -clamped : clamped;
        end
    end

    assign o_sine = r_sine;

endmodule

/* rtl/core/ajv_jacobian.sv */
// Builds the linear and angular Jacobian rows from the trig values and link
// dimensions in four pipeline stages. Depends on ajv_pkg.
module ajv_jacobian (
    input  logic           i_clk,
    input  logic           i_en,
    input  ajv_pkg::t_coef i_trig [0:9],
    input  ajv_pkg::t_rate i_a2,
    input  ajv_pkg::t_rate i_a3,
    input  ajv_pkg::t_rate i_d3,
    input  ajv_pkg::t_rate i_d4,
    output ajv_pkg::t_coef o_jl [0:2][0:5],
    output ajv_pkg::t_coef o_ja [0:2][0:5]
);
    import ajv_pkg::*;

    t_coef s1, c1, s2, c2, s4, c4, s5, c5, s23, c23;
    t_coef a2, a3, d3, d4;

    // Stage 1
    t_coef r1_d4s23, r1_a3c23, r1_d4c23, r1_a3s23, r1_a2c2, r1_a2s2, r1_d3c1, r1_d3s1;
    t_coef r1_c4s5, r1_s4s5, r1_s4c23, r1_s4s23, r1_c5s23, r1_c5c23;
    t_coef r1_c1s23, r1_s1s23, r1_c1c4, r1_s1c4, r1_s1, r1_c1, r1_s23, r1_c23;
    // Stage 2
    t_coef r2_a, r2_b, r2_a2c2, r2_a2s2, r2_d3c1, r2_d3s1, r2_t, r2_ja25;
    t_coef r2_c1s4c23, r2_s1s4c23, r2_s1s4s5, r2_c1s4s5;
    t_coef r2_c1s23, r2_s1s23, r2_c1c4, r2_s1c4, r2_s4s23, r2_s1, r2_c1, r2_c23;
    // Stage 3
    t_coef r3_p, r3_q, r3_a, r3_b, r3_d3c1, r3_d3s1, r3_ja04, r3_ja14;
    t_coef r3_c1t, r3_s1t, r3_s1s4s5, r3_c1s4s5, r3_ja25;
    t_coef r3_c1s23, r3_s1s23, r3_s4s23, r3_s1, r3_c1, r3_c23;
    // Stage 4
    t_coef r_jl [0:2][0:5];
    t_coef r_ja [0:2][0:5];

    function automatic t_coef sat_c(input t_coef v);
        return t_coef'(sat32(t_sum'(v)));
    endfunction

    always_comb begin
        s1  = i_trig[L_S1];
        c1  = i_trig[L_C1];
        s2  = i_trig[L_S2];
        c2  = i_trig[L_C2];
        s4  = i_trig[L_S4];
        c4  = i_trig[L_C4];
        s5  = i_trig[L_S5];
        c5  = i_trig[L_C5];
        s23 = i_trig[L_S23];
        c23 = i_trig[L_C23];
        a2  = t_coef'(i_a2);
        a3  = t_coef'(i_a3);
        d3  = t_coef'(i_d3);
        d4  = t_coef'(i_d4);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d4s23 <= mq(d4, s23);
            r1_a3c23 <= mq(a3, c23);
            r1_d4c23 <= mq(d4, c23);
            r1_a3s23 <= mq(a3, s23);
            r1_a2c2  <= mq(a2, c2);
            r1_a2s2  <= mq(a2, s2);
            r1_d3c1  <= mq(d3, c1);
            r1_d3s1  <= mq(d3, s1);
            r1_c4s5  <= mq(c4, s5);
            r1_s4s5  <= mq(s4, s5);
            r1_s4c23 <= mq(s4, c23);
            r1_s4s23 <= mq(s4, s23);
            r1_c5s23 <= mq(c5, s23);
            r1_c5c23 <= mq(c5, c23);
            r1_c1s23 <= mq(c1, s23);
            r1_s1s23 <= mq(s1, s23);
            r1_c1c4  <= mq(c1, c4);
            r1_s1c4  <= mq(s1, c4);
            r1_s1    <= s1;
            r1_c1    <= c1;
            r1_s23   <= s23;
            r1_c23   <= c23;

            r2_a       <= r1_d4s23 - r1_a3c23;
            r2_b       <= r1_d4c23 + r1_a3s23;
            r2_a2c2    <= r1_a2c2;
            r2_a2s2    <= r1_a2s2;
            r2_d3c1    <= r1_d3c1;
            r2_d3s1    <= r1_d3s1;
            r2_t       <= mq(r1_c4s5, r1_c23) + r1_c5s23;
            r2_ja25    <= mq(r1_c4s5, r1_s23) - r1_c5c23;
            r2_c1s4c23 <= mq(r1_c1, r1_s4c23);
            r2_s1s4c23 <= mq(r1_s1, r1_s4c23);
            r2_s1s4s5  <= mq(r1_s1, r1_s4s5);
            r2_c1s4s5  <= mq(r1_c1, r1_s4s5);
            r2_c1s23   <= r1_c1s23;
            r2_s1s23   <= r1_s1s23;
            r2_c1c4    <= r1_c1c4;
            r2_s1c4    <= r1_s1c4;
            r2_s4s23   <= r1_s4s23;
            r2_s1      <= r1_s1;
            r2_c1      <= r1_c1;
            r2_c23     <= r1_c23;

            r3_p      <= r2_a - r2_a2c2;
            r3_q      <= r2_b + r2_a2s2;
            r3_a      <= r2_a;
            r3_b      <= r2_b;
            r3_d3c1   <= r2_d3c1;
            r3_d3s1   <= r2_d3s1;
            r3_ja04   <= r2_c1s4c23 - r2_s1c4;
            r3_ja14   <= r2_s1s4c23 + r2_c1c4;
            r3_c1t    <= mq(r2_c1, r2_t);
            r3_s1t    <= mq(r2_s1, r2_t);
            r3_s1s4s5 <= r2_s1s4s5;
            r3_c1s4s5 <= r2_c1s4s5;
            r3_ja25   <= r2_ja25;
            r3_c1s23  <= r2_c1s23;
            r3_s1s23  <= r2_s1s23;
            r3_s4s23  <= r2_s4s23;
            r3_s1     <= r2_s1;
            r3_c1     <= r2_c1;
            r3_c23    <= r2_c23;

            // Linear rows, each entry saturated to 32 bits.
            r_jl[0][0] <= sat_c(mq(r3_s1, r3_p) - r3_d3c1);
            r_jl[0][1] <= sat_c(-mq(r3_c1, r3_q));
            r_jl[0][2] <= sat_c(-mq(r3_c1, r3_b));
            r_jl[1][0] <= sat_c(-mq(r3_c1, r3_p) - r3_d3s1);
            r_jl[1][1] <= sat_c(-mq(r3_s1, r3_q));
            r_jl[1][2] <= sat_c(-mq(r3_s1, r3_b));
            r_jl[2][0] <= '0;
            r_jl[2][1] <= sat_c(r3_p);
            r_jl[2][2] <= sat_c(r3_a);
            for (int i = 0; i < 3; i++) begin
                for (int j = 3; j < 6; j++) begin
                    r_jl[i][j] <= '0;
                end
            end

            // Angular rows.
            r_ja[0][0] <= '0;
            r_ja[0][1] <= -r3_s1;
            r_ja[0][2] <= -r3_s1;
            r_ja[0][3] <= -r3_c1s23;
            r_ja[0][4] <= r3_ja04;
            r_ja[0][5] <= -r3_c1t - r3_s1s4s5;
            r_ja[1][0] <= '0;
            r_ja[1][1] <= r3_c1;
            r_ja[1][2] <= r3_c1;
            r_ja[1][3] <= -r3_s1s23;
            r_ja[1][4] <= r3_ja14;
            r_ja[1][5] <= -r3_s1t + r3_c1s4s5;
            r_ja[2][0] <= TRIG_ONE;
            r_ja[2][1] <= '0;
            r_ja[2][2] <= '0;
            r_ja[2][3] <= -r3_c23;
            r_ja[2][4] <= -r3_s4s23;
            r_ja[2][5] <= r3_ja25;
        end
    end

    assign o_jl = r_jl;
    assign o_ja = r_ja;

endmodule

/* rtl/core/ajv_row.sv */
// One row lane: six coefficient-times-rate products, then their sum.
// Depends on ajv_pkg.
module ajv_row (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic           i_angular,
    input  ajv_pkg::t_coef i_coef [0:5],
    input  ajv_pkg::t_rate i_rate [0:5],
    output ajv_pkg::t_sum  o_sum
);
    import ajv_pkg::*;

    logic signed [67:0] prod [0:5];
    logic signed [67:0] r_prod [0:5];
    t_sum               sum;
    t_sum               r_sum;

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            prod[j] = i_coef[j] * i_rate[j];
            // Angular entries are Q30, linear entries carry the rate format.
            prod[j] = i_angular ? (prod[j] >>> 30) : (prod[j] >>> FRAC_BITS);
        end
        sum = '0;
        for (int j = 0; j < 6; j++) begin
            sum = sum + t_sum'(r_prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= prod;
            r_sum  <= sum;
        end
    end

    assign o_sum = r_sum;

endmodule

/* rtl/core/arm_jacobian_velocity_core.sv */
// Top level of the arm velocity Jacobian core: input register, ten sine lanes,
// Jacobian builder, six row lanes and the saturating output stage. Uses ajv_pkg.
//
//  channel  direction  handshake            payload
//  in       to core     i_in_valid/o_in_stall   i_in_data  (ajv_pkg::t_in)
//  out      from core   o_out_valid/i_out_stall o_out_data (ajv_pkg::t_out)
//  cfg      to core     i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// The core takes one item every cycle unless it stalls; most of the depth comes
// from the eight-stage Horner pipeline in each sine lane and the four dependent
// multiply levels of the Jacobian builder.
// The whole pipeline advances together: it freezes only while a result sits in
// the output register and the receiver stalls, and then o_in_stall is raised.
// Reset clears the stage valid bits and loads the default link dimensions.
module arm_jacobian_velocity_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ajv_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ajv_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import ajv_pkg::*;

    // Pipeline enable: every stage moves unless a finished item is held.
    logic en;

    logic [PIPE_DEPTH-1:0] r_vld;
    t_in                   r_in;
    t_rate                 r_rate [0:RATE_DELAY-1][0:5];
    t_rate                 rate_in [0:5];
    t_out                  r_out;

    // Link dimensions.
    t_rate r_a2, r_a3, r_d3, r_d4;

    t_angle q1, q2, q4, q5, q23;
    t_angle lane_angle [0:SIN_LANES-1];
    t_coef  trig [0:SIN_LANES-1];
    t_coef  jl [0:2][0:5];
    t_coef  ja [0:2][0:5];
    t_sum   row_sum [0:5];

    assign en          = !r_vld[PIPE_DEPTH-1] || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    // Configuration writes; indexes past the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a2 <= 32'sd19661;
            r_a3 <= 32'sd3277;
            r_d3 <= 32'sd4588;
            r_d4 <= 32'sd26214;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_UPPER_ARM:      r_a2 <= i_cfg_data;
                CFG_FOREARM_OFFSET: r_a3 <= i_cfg_data;
                CFG_SHOULDER:       r_d3 <= i_cfg_data;
                CFG_FOREARM_LENGTH: r_d4 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        rate_in[0] = r_in.joint1_rate;
        rate_in[1] = r_in.joint2_rate;
        rate_in[2] = r_in.joint3_rate;
        rate_in[3] = r_in.joint4_rate;
        rate_in[4] = r_in.joint5_rate;
        rate_in[5] = r_in.joint6_rate;

        // Every angle bit counts, and joint 3 enters through the
        // wrapped sum of joints two and three. The joint 6 angle has no effect.
        q1  = r_in.joint1_angle[ANGLE_BITS-1:0];
        q2  = r_in.joint2_angle[ANGLE_BITS-1:0];
        q4  = r_in.joint4_angle[ANGLE_BITS-1:0];
        q5  = r_in.joint5_angle[ANGLE_BITS-1:0];
        q23 = q2 + r_in.joint3_angle[ANGLE_BITS-1:0];

        // A cosine is the sine a quarter turn further on.
        lane_angle[L_S1]  = q1;
        lane_angle[L_C1]  = q1 + QUARTER_TURN;
        lane_angle[L_S2]  = q2;
        lane_angle[L_C2]  = q2 + QUARTER_TURN;
        lane_angle[L_S4]  = q4;
        lane_angle[L_C4]  = q4 + QUARTER_TURN;
        lane_angle[L_S5]  = q5;
        lane_angle[L_C5]  = q5 + QUARTER_TURN;
        lane_angle[L_S23] = q23;
        lane_angle[L_C23] = q23 + QUARTER_TURN;
    end

    // Input register and the rate delay line that keeps rates level with
    // the Jacobian entries of the same item.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in      <= i_in_data;
            r_rate[0] <= rate_in;
            for (int k = 1; k < RATE_DELAY; k++) begin
                r_rate[k] <= r_rate[k-1];
            end
        end
    end

    for (genvar g = 0; g < SIN_LANES; g++) begin : g_sine
        ajv_sine u_sine (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_angle (lane_angle[g]),
            .o_sine  (trig[g])
        );
    end

    ajv_jacobian u_jacobian (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_trig (trig),
        .i_a2   (r_a2),
        .i_a3   (r_a3),
        .i_d3   (r_d3),
        .i_d4   (r_d4),
        .o_jl   (jl),
        .o_ja   (ja)
    );

    // Lanes 0 to 2 take the linear rows, lanes 3 to 5 the angular rows.
    for (genvar g = 0; g < 3; g++) begin : g_rows
        ajv_row u_lin (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_angular (1'b0),
            .i_coef    (jl[g]),
            .i_rate    (r_rate[RATE_DELAY-1]),
            .o_sum     (row_sum[g])
        );
        ajv_row u_ang (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_angular (1'b1),
            .i_coef    (ja[g]),
            .i_rate    (r_rate[RATE_DELAY-1]),
            .o_sum     (row_sum[g+3])
        );
    end

    // Merge stage: saturate each row sum into the output item.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.linear_vel_x  <= sat32(row_sum[0]);
            r_out.linear_vel_y  <= sat32(row_sum[1]);
            r_out.linear_vel_z  <= sat32(row_sum[2]);
            r_out.angular_vel_x <= sat32(row_sum[3]);
            r_out.angular_vel_y <= sat32(row_sum[4]);
            r_out.angular_vel_z <= sat32(row_sum[5]);
        end
    end

endmodule
